// ===== rtl/tile_video_register_interface_unit_defines.svh =====
// Assertion macros for the tile video register interface unit.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef TILE_VIDEO_REGISTER_INTERFACE_UNIT_DEFINES_SVH
`define TILE_VIDEO_REGISTER_INTERFACE_UNIT_DEFINES_SVH

// check a condition on the same edge
`define TVRI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a condition on the next edge
`define TVRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tvri_pkg.sv =====
// Package for the tile video register interface unit: types, constants,
// address mapping and scroll helper functions. No dependencies.
package tvri_pkg;

    localparam int AddrW     = 15;
    localparam int VidW      = 14;
    localparam int VramDepth = 10240;
    localparam int VramAw    = 14;
    localparam int OamDepth  = 256;
    localparam int OamAw     = 8;
    localparam int PalDepth  = 32;

    localparam logic [VidW-1:0]  PaletteBase = 14'h3F00;
    localparam logic [VidW-1:0]  PaletteBack = 14'h1000;
    localparam logic [AddrW-1:0] HorizBits   = 15'h041F;
    localparam logic [AddrW-1:0] VertBits    = 15'h7BE0;
    localparam logic [8:0]       LastDot     = 9'd340;
    localparam logic [8:0]       LastLine    = 9'd261;
    localparam logic [8:0]       VblankLine  = 9'd241;
    localparam logic [8:0]       VisLines    = 9'd240;
    localparam logic [8:0]       DotStepY    = 9'd256;
    localparam logic [8:0]       DotCopyH    = 9'd257;
    localparam logic [8:0]       DotVFirst   = 9'd280;
    localparam logic [8:0]       DotVLast    = 9'd304;

    localparam logic [2:0] RegCtrl   = 3'd0;
    localparam logic [2:0] RegMask   = 3'd1;
    localparam logic [2:0] RegStatus = 3'd2;
    localparam logic [2:0] RegOamAdr = 3'd3;
    localparam logic [2:0] RegOamDat = 3'd4;
    localparam logic [2:0] RegScroll = 3'd5;
    localparam logic [2:0] RegAddr   = 3'd6;
    localparam logic [2:0] RegData   = 3'd7;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_DMA   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RSEL_DIRECT = 3'b001,
        RSEL_OAM    = 3'b010,
        RSEL_VDATA  = 3'b100
    } t_rsel;

    typedef struct packed {
        t_rsel      sel;
        logic       pal;
        logic [7:0] byte_val;
        logic       nmi;
    } t_s1;

    function automatic logic [VramAw-1:0] vram_index(logic [VidW-1:0] a, logic mirror);
        logic page;
        page = mirror ? a[10] : a[11];
        if (a < 14'h2000) begin
            return {1'b0, a[12:0]};
        end
        return {1'b1, 2'b00, page, a[9:0]};
    endfunction

    function automatic logic [4:0] pal_index(logic [VidW-1:0] a);
        logic [4:0] p;
        p = a[4:0];
        if (p[1:0] == 2'b00) begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

    function automatic logic [AddrW-1:0] step_y(logic [AddrW-1:0] v);
        logic [4:0]       y;
        logic [AddrW-1:0] r;
        r = v;
        y = v[9:5];
        if (v[14:12] != 3'b111) begin
            r[14:12] = v[14:12] + 3'd1;
        end else begin
            r[14:12] = 3'd0;
            if (y == 5'd29) begin
                y = 5'd0;
                r[11] = ~r[11];
            end else if (y == 5'd31) begin
                y = 5'd0;
            end else begin
                y = y + 5'd1;
            end
            r[9:5] = y;
        end
        return r;
    endfunction

endpackage

// ===== rtl/tvri_in_if.sv =====
// Request channel of the tile video register interface unit.
// Depends on nothing.
interface tvri_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] reg_select;
    logic [7:0] data_in;
    logic [7:0] dma_index;

    modport source (output valid, kind, reg_select, data_in, dma_index, input ready);
    modport sink (input valid, kind, reg_select, data_in, dma_index, output ready);
endinterface

// ===== rtl/tvri_out_if.sv =====
// Result channel of the tile video register interface unit.
// Depends on nothing.
interface tvri_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       nmi_pulse;

    modport source (output valid, read_data, nmi_pulse, input ready);
    modport sink (input valid, read_data, nmi_pulse, output ready);
endinterface

// ===== rtl/tvri_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tvri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/tile_video_register_interface_unit.sv =====
// Top level of the tile video register interface unit.
// Depends on tvri_pkg, tvri_in_if, tvri_out_if, tvri_ram and the defines header.
//
// Usage:
//   i_in carries requests: dot tick, register read, register write or OAM DMA
//   byte. o_out returns one result per request: read_data (zero unless a read)
//   and nmi_pulse (set on the tick that starts vblank with NMI enabled).
//   i_cfg_we/i_cfg_wdata set nametable mirroring (0 horizontal, 1 vertical);
//   write it only while no request is in flight.
// Pipeline: an accepted request's memory read is registered with stage 1, then
//   its result is registered in the output register that drives o_out.
// Throughput: one request per cycle while o_out is ready; scalar state updates
//   at acceptance and the read buffer after it, so no request waits on another.
//   The video and OAM memories each have one read and one write port.
// Reset: all registers, the palette and OAM contents read as zero; pattern
//   and nametable memory hold unknown data until written.
// Stall: when o_out.ready is low the output register and the memory read
//   stage hold; i_in.ready drops once both are full.
module tile_video_register_interface_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    tvri_in_if.sink       i_in,
    tvri_out_if.source    o_out
);
    import tvri_pkg::*;

    logic             r_mirror;
    logic [7:0]       r_ctrl, n_ctrl;
    logic [7:0]       r_mask, n_mask;
    logic [2:0]       r_status, n_status;
    logic [AddrW-1:0] r_v, n_v;
    logic [AddrW-1:0] r_t, n_t;
    logic [2:0]       r_fine_x, n_fine_x;
    logic             r_toggle, n_toggle;
    logic [7:0]       r_sma, n_sma;
    logic [8:0]       r_dot, n_dot;
    logic [8:0]       r_line, n_line;
    logic [7:0]       r_buf;
    logic [7:0]       r_pal [PalDepth];
    logic [OamDepth-1:0] r_oam_valid;

    logic             r_s1_valid;
    t_s1              r_s1, n_s1;
    logic             r_s1_oam_ok;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             r_out_nmi;

    logic              accept, s1_adv;
    logic              vram_we, vram_re, oam_we, oam_re, pal_we;
    logic [VramAw-1:0] vram_waddr, vram_raddr;
    logic [OamAw-1:0]  oam_waddr;
    logic [4:0]        pal_waddr;
    logic [7:0]        wdata;
    logic [7:0]        vram_rdata, oam_rdata;
    logic [7:0]        s1_data;
    logic [VidW-1:0]   va;
    logic              rendering;

    assign s1_adv  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign accept  = i_in.valid && i_in.ready;
    assign va      = r_v[VidW-1:0];
    assign rendering = |r_mask[4:3];
    assign wdata   = i_in.data_in;

    always_comb begin
        n_ctrl = r_ctrl; n_mask = r_mask; n_status = r_status;
        n_v = r_v; n_t = r_t; n_fine_x = r_fine_x; n_toggle = r_toggle;
        n_sma = r_sma; n_dot = r_dot; n_line = r_line;
        n_s1 = '{sel: RSEL_DIRECT, pal: 1'b0, byte_val: 8'd0, nmi: 1'b0};
        vram_we = 1'b0; vram_re = 1'b0; oam_we = 1'b0; oam_re = 1'b0; pal_we = 1'b0;
        vram_waddr = vram_index(va, r_mirror);
        vram_raddr = vram_index(va, r_mirror);
        oam_waddr = r_sma;
        pal_waddr = pal_index(va);
        unique case (t_kind'(i_in.kind))
            KIND_TICK: begin
                n_dot = r_dot + 9'd1;
                if (r_dot == LastDot) begin
                    n_dot = 9'd0;
                    n_line = (r_line == LastLine) ? 9'd0 : r_line + 9'd1;
                end
                if (n_line < VisLines) begin
                    if (rendering && n_dot == DotStepY) begin
                        n_v = step_y(r_v);
                    end else if (rendering && n_dot == DotCopyH) begin
                        n_v = (r_v & ~HorizBits) | (r_t & HorizBits);
                    end
                end else if (n_line == VblankLine && n_dot == 9'd1) begin
                    n_status[2] = 1'b1;
                    n_s1.nmi = r_ctrl[7];
                end else if (n_line == LastLine) begin
                    if (n_dot == 9'd1) begin
                        n_status = 3'd0;
                    end
                    if (rendering && n_dot >= DotVFirst && n_dot <= DotVLast) begin
                        n_v = (r_v & ~VertBits) | (r_t & VertBits);
                    end
                end
            end
            KIND_READ: begin
                unique case (i_in.reg_select)
                    RegStatus: begin
                        n_s1.byte_val = {r_status, 5'd0};
                        n_status[2] = 1'b0;
                        n_toggle = 1'b0;
                    end
                    RegOamDat: begin
                        n_s1.sel = RSEL_OAM;
                        oam_re = 1'b1;
                    end
                    RegData: begin
                        n_s1.sel = RSEL_VDATA;
                        vram_re = 1'b1;
                        if (va >= PaletteBase) begin
                            n_s1.pal = 1'b1;
                            n_s1.byte_val = r_pal[pal_index(va)];
                            vram_raddr = vram_index(va - PaletteBack, r_mirror);
                        end
                        n_v = r_v + (r_ctrl[2] ? 15'd32 : 15'd1);
                    end
                    default: begin
                    end
                endcase
            end
            KIND_WRITE: begin
                unique case (i_in.reg_select)
                    RegCtrl: begin
                        n_ctrl = wdata;
                        n_t[11:10] = wdata[1:0];
                    end
                    RegMask: n_mask = wdata;
                    RegOamAdr: n_sma = wdata;
                    RegOamDat: begin
                        oam_we = 1'b1;
                        n_sma = r_sma + 8'd1;
                    end
                    RegScroll: begin
                        if (!r_toggle) begin
                            n_t[4:0] = wdata[7:3];
                            n_fine_x = wdata[2:0];
                        end else begin
                            n_t[9:5] = wdata[7:3];
                            n_t[14:12] = wdata[2:0];
                        end
                        n_toggle = ~r_toggle;
                    end
                    RegAddr: begin
                        if (!r_toggle) begin
                            n_t[13:8] = wdata[5:0];
                            n_t[14] = 1'b0;
                        end else begin
                            n_t[7:0] = wdata;
                            n_v = {r_t[14:8], wdata};
                        end
                        n_toggle = ~r_toggle;
                    end
                    RegData: begin
                        if (va < PaletteBase) begin
                            vram_we = 1'b1;
                        end else begin
                            pal_we = 1'b1;
                        end
                        n_v = r_v + (r_ctrl[2] ? 15'd32 : 15'd1);
                    end
                    default: begin
                    end
                endcase
            end
            KIND_DMA: begin
                oam_we = 1'b1;
                oam_waddr = i_in.dma_index;
            end
            default: begin
            end
        endcase
    end

    tvri_ram #(.WIDTH(8), .DEPTH(VramDepth)) u_vram (
        .i_clk   (i_clk),
        .i_we    (accept && vram_we),
        .i_waddr (vram_waddr),
        .i_wdata (wdata),
        .i_re    (accept && vram_re),
        .i_raddr (vram_raddr),
        .o_rdata (vram_rdata)
    );

    tvri_ram #(.WIDTH(8), .DEPTH(OamDepth)) u_oam (
        .i_clk   (i_clk),
        .i_we    (accept && oam_we),
        .i_waddr (oam_waddr),
        .i_wdata (wdata),
        .i_re    (accept && oam_re),
        .i_raddr (r_sma),
        .o_rdata (oam_rdata)
    );

    always_comb begin
        case (r_s1.sel)
            RSEL_OAM:   s1_data = r_s1_oam_ok ? oam_rdata : 8'd0;
            RSEL_VDATA: s1_data = r_s1.pal ? r_s1.byte_val : r_buf;
            default:    s1_data = r_s1.byte_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror <= 1'b0;
            r_ctrl <= '0; r_mask <= '0; r_status <= '0;
            r_v <= '0; r_t <= '0; r_fine_x <= '0; r_toggle <= 1'b0;
            r_sma <= '0; r_dot <= '0; r_line <= '0; r_buf <= '0;
            r_oam_valid <= '0;
            for (int i = 0; i < PalDepth; i++) begin
                r_pal[i] <= '0;
            end
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mirror <= i_cfg_wdata;
            end
            if (accept) begin
                r_ctrl <= n_ctrl; r_mask <= n_mask; r_status <= n_status;
                r_v <= n_v; r_t <= n_t; r_fine_x <= n_fine_x; r_toggle <= n_toggle;
                r_sma <= n_sma; r_dot <= n_dot; r_line <= n_line;
                if (oam_we) begin
                    r_oam_valid[oam_waddr] <= 1'b1;
                end
                if (pal_we) begin
                    r_pal[pal_waddr] <= wdata;
                end
            end
            if (s1_adv && r_s1.sel == RSEL_VDATA) begin
                r_buf <= vram_rdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
            r_s1_oam_ok <= r_oam_valid[r_sma];
        end
        if (s1_adv) begin
            r_out_data <= s1_data;
            r_out_nmi <= r_s1.nmi;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.nmi_pulse = r_out_nmi;

`include "tile_video_register_interface_unit_defines.svh"

    `TVRI_ASSERT_NOW(a_dot_range, 1'b1, r_dot <= LastDot, "dot counter out of range")
    `TVRI_ASSERT_NOW(a_stall_blocks, r_s1_valid && r_out_valid && !o_out.ready,
        !i_in.ready, "request accepted while pipeline is full")
    `TVRI_ASSERT_NEXT(a_accept_fills, accept, r_s1_valid, "accepted request lost")
    `TVRI_ASSERT_NOW(a_nmi_no_data, r_s1_valid && r_s1.nmi, r_s1.sel == RSEL_DIRECT &&
        r_s1.byte_val == 8'd0, "nmi on a read request")
endmodule

// ===== bench/testbench.sv =====
// Testbench for tile_video_register_interface_unit: directed, random, scanline and stall tests.
// It predicts each result from its own copy of the register and memory state.
// Depends on tvri_pkg, tvri_in_if, tvri_out_if and the unit RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tvri_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int LineTicks  = 360;

    typedef struct {
        logic [7:0] read_data;
        logic       nmi_pulse;
    } t_expected;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    tvri_in_if  req_bus();
    tvri_out_if res_bus();

    tile_video_register_interface_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req_bus),
        .o_out       (res_bus)
    );

    // video unit state as predicted
    logic        mirror;
    logic [7:0]  ctrl_q, mask_q, oam_addr, rd_buffer;
    logic [2:0]  flags_q, fine_x;
    logic [14:0] vaddr, taddr;
    logic        toggle_q;
    int          dot_q, line_q;
    logic [7:0]  pattern_mem [8192];
    logic [7:0]  name_mem [2048];
    logic [7:0]  palette_mem [32];
    logic [7:0]  oam_mem [256];
    bit          pattern_set [8192];
    bit          name_set [2048];

    t_expected   expected_results [$];
    int          errors = 0;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          nmi_seen = 0;
    int          cycle_count = 0;
    bit          idle_on = 1;
    int          stall_left = 0;
    int          rx_wait = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic int name_slot(logic [13:0] a);
        logic page;
        page = mirror ? a[10] : a[11];
        return {page, a[9:0]};
    endfunction

    function automatic int palette_slot(logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if ((p & 5'h13) == 5'h10) p[4] = 1'b0;
        return p;
    endfunction

    function automatic bit entry_written(logic [13:0] a);
        if (a < 14'h2000) return pattern_set[a];
        if (a < 14'h3F00) return name_set[name_slot(a)];
        return 1'b1;
    endfunction

    function automatic bit data_read_safe();
        logic [13:0] a;
        a = vaddr[13:0];
        if (a < 14'h3F00) return entry_written(a);
        return entry_written(a - 14'h1000);
    endfunction

    function automatic logic [7:0] video_fetch(logic [13:0] a);
        if (a < 14'h2000) return pattern_mem[a];
        if (a < 14'h3F00) return name_mem[name_slot(a)];
        return palette_mem[palette_slot(a)];
    endfunction

    task automatic video_store(logic [13:0] a, logic [7:0] d);
        if (a < 14'h2000) begin
            pattern_mem[a] = d;
            pattern_set[a] = 1'b1;
        end else if (a < 14'h3F00) begin
            name_mem[name_slot(a)] = d;
            name_set[name_slot(a)] = 1'b1;
        end else begin
            palette_mem[palette_slot(a)] = d;
        end
    endtask

    function automatic logic [14:0] next_fine_y(logic [14:0] v);
        logic [14:0] r;
        logic [4:0]  y;
        r = v;
        if (v[14:12] != 3'b111) begin
            r[14:12] = v[14:12] + 3'd1;
        end else begin
            r[14:12] = 3'd0;
            y = v[9:5];
            if (y == 5'd29) begin
                y = 5'd0;
                r[11] = ~r[11];
            end else if (y == 5'd31) begin
                y = 5'd0;
            end else begin
                y = y + 5'd1;
            end
            r[9:5] = y;
        end
        return r;
    endfunction

    task automatic bump_address();
        vaddr = vaddr + (ctrl_q[2] ? 15'd32 : 15'd1);
    endtask

    task automatic advance_dot(output logic nmi);
        bit drawing;
        nmi = 1'b0;
        drawing = (mask_q & 8'h18) != 0;
        dot_q++;
        if (dot_q > LastDot) begin
            dot_q = 0;
            line_q++;
            if (line_q > LastLine) line_q = 0;
        end
        if (line_q < VisLines) begin
            if (drawing && dot_q == DotStepY) vaddr = next_fine_y(vaddr);
            else if (drawing && dot_q == DotCopyH) vaddr = (vaddr & ~HorizBits) | (taddr & HorizBits);
        end else if (line_q == VblankLine && dot_q == 1) begin
            flags_q[2] = 1'b1;
            nmi = ctrl_q[7];
        end else if (line_q == LastLine) begin
            if (dot_q == 1) flags_q = 3'b000;
            if (drawing && dot_q >= DotVFirst && dot_q <= DotVLast)
                vaddr = (vaddr & ~VertBits) | (taddr & VertBits);
        end
    endtask

    task automatic register_read(logic [2:0] r, output logic [7:0] d);
        logic [13:0] a;
        d = 8'h00;
        case (r)
            RegStatus: begin
                d = {flags_q, 5'b00000};
                flags_q[2] = 1'b0;
                toggle_q = 1'b0;
            end
            RegOamDat: d = oam_mem[oam_addr];
            RegData: begin
                a = vaddr[13:0];
                d = video_fetch(a);
                if (a < 14'h3F00) begin
                    d = rd_buffer;
                    rd_buffer = video_fetch(a);
                end else begin
                    rd_buffer = video_fetch(a - 14'h1000);
                end
                bump_address();
            end
            default: d = 8'h00;
        endcase
    endtask

    task automatic register_write(logic [2:0] r, logic [7:0] d);
        logic [15:0] t;
        t = {1'b0, taddr};
        case (r)
            RegCtrl: begin
                ctrl_q = d;
                t = (t & 16'hF3FF) | (16'(d[1:0]) << 10);
            end
            RegMask: mask_q = d;
            RegOamAdr: oam_addr = d;
            RegOamDat: begin
                oam_mem[oam_addr] = d;
                oam_addr = oam_addr + 8'd1;
            end
            RegScroll: begin
                if (!toggle_q) begin
                    t = (t & ~16'h001F) | 16'(d >> 3);
                    fine_x = d[2:0];
                    toggle_q = 1'b1;
                end else begin
                    t = (t & 16'h8C1F) | (16'(d & 8'hF8) << 2);
                    t = (t & 16'h0FFF) | (16'(d[2:0]) << 12);
                    toggle_q = 1'b0;
                end
            end
            RegAddr: begin
                if (!toggle_q) begin
                    t = (t & 16'h00FF) | (16'(d[5:0]) << 8);
                    toggle_q = 1'b1;
                end else begin
                    t = (t & 16'hFF00) | 16'(d);
                    vaddr = t[14:0];
                    toggle_q = 1'b0;
                end
            end
            RegData: begin
                video_store(vaddr[13:0], d);
                bump_address();
            end
            default: ;
        endcase
        taddr = t[14:0];
    endtask

    task automatic predict_request(t_kind k, logic [2:0] r, logic [7:0] d, logic [7:0] x);
        t_expected e;
        e.read_data = 8'h00;
        e.nmi_pulse = 1'b0;
        case (k)
            KIND_TICK:  advance_dot(e.nmi_pulse);
            KIND_READ:  register_read(r, e.read_data);
            KIND_WRITE: register_write(r, d);
            default:    oam_mem[x] = d;
        endcase
        expected_results.push_back(e);
    endtask

    // send one request; an unsafe video read becomes a video write
    task automatic send_req(t_kind k, logic [2:0] r, logic [7:0] d, logic [7:0] x);
        int gap;
        if (k == KIND_READ && r == RegData && !data_read_safe()) k = KIND_WRITE;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.kind = k;
        req_bus.reg_select = r;
        req_bus.data_in = d;
        req_bus.dma_index = x;
        req_bus.valid = 1'b1;
        do @(posedge i_clk); while (!req_bus.ready);
        predict_request(k, r, d, x);
        requests_sent++;
    endtask

    task automatic wr(logic [2:0] r, logic [7:0] d);
        send_req(KIND_WRITE, r, d, 8'($urandom_range(0, 255)));
    endtask

    task automatic rd(logic [2:0] r);
        send_req(KIND_READ, r, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic set_address(logic [13:0] a);
        wr(RegAddr, {2'($urandom_range(0, 3)), a[13:8]});
        wr(RegAddr, a[7:0]);
    endtask

    // drop valid and hold until every expected result has come
    task automatic wait_drain();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_mirror(logic m);
        wait_drain();
        i_cfg_wdata = m;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        mirror = m;
    endtask

    // receiver: per-result wait or a long hold-off
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_bus.ready = 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            res_bus.ready = 1'b0;
        end else begin
            res_bus.ready = i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        t_expected e;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            results_seen++;
            rx_wait = idle_on ? $urandom_range(0, 19) : 0;
            if (expected_results.size() == 0) begin
                errors++;
                $error("unexpected result read_data=%h nmi_pulse=%b",
                       res_bus.read_data, res_bus.nmi_pulse);
            end else begin
                e = expected_results.pop_front();
                if (res_bus.nmi_pulse) nmi_seen++;
                if (res_bus.read_data !== e.read_data) begin
                    errors++;
                    $error("read_data expected %h actual %h", e.read_data, res_bus.read_data);
                end
                if (res_bus.nmi_pulse !== e.nmi_pulse) begin
                    errors++;
                    $error("nmi_pulse expected %b actual %b", e.nmi_pulse, res_bus.nmi_pulse);
                end
            end
        end
    end

    task automatic test_directed();
        wr(RegCtrl, 8'h00);
        wr(RegMask, 8'h00);
        wr(RegStatus, 8'hA5);
        rd(RegCtrl);
        rd(RegMask);
        rd(RegOamAdr);
        rd(RegScroll);
        rd(RegAddr);
        wr(RegOamAdr, 8'hFF);
        wr(RegOamDat, 8'hFF);
        rd(RegOamDat);
        send_req(KIND_DMA, RegCtrl, 8'h00, 8'hFF);
        send_req(KIND_DMA, RegData, 8'hFF, 8'h00);
        rd(RegOamDat);
        wr(RegScroll, 8'hFF);
        wr(RegScroll, 8'hFF);
        set_address(14'h2F00);
        wr(RegData, 8'h77);
        set_address(14'h3F10);
        wr(RegData, 8'h2A);
        set_address(14'h3F00);
        rd(RegData);
        rd(RegStatus);
        wr(RegCtrl, 8'h04);
        set_address(14'h0000);
        wr(RegData, 8'h11);
        wr(RegData, 8'h22);
        set_address(14'h0000);
        rd(RegData);
        rd(RegData);
        rd(RegData);
        send_req(KIND_TICK, RegCtrl, 8'h00, 8'h00);
        wait_drain();
    endtask

    task automatic random_sequence();
        logic [13:0] a;
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                case ($urandom_range(0, 3))
                    0: a = 14'($urandom_range(0, 31)) | (14'($urandom_range(0, 1)) << 12);
                    1: a = 14'h2000 | (14'($urandom_range(0, 3)) << 10) | 14'($urandom_range(0, 31));
                    2: a = 14'h3000 | (14'($urandom_range(0, 3)) << 10) | 14'($urandom_range(0, 31));
                    default: a = 14'h3F00 | 14'($urandom_range(0, 255));
                endcase
                n = $urandom_range(1, 4);
                set_address(a);
                repeat (n) wr(RegData, 8'($urandom_range(0, 255)));
                set_address(a);
                repeat (n + 1) rd(RegData);
            end
            5: begin
                wr(RegScroll, 8'($urandom_range(0, 255)));
                wr(RegScroll, 8'($urandom_range(0, 255)));
            end
            6: begin
                wr(RegOamAdr, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 3)) wr(RegOamDat, 8'($urandom_range(0, 255)));
                send_req(KIND_DMA, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
                rd(RegOamDat);
            end
            7: repeat ($urandom_range(1, 30))
                send_req(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            8: send_req(t_kind'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            default: begin
                wr(RegCtrl, 8'($urandom_range(0, 255)));
                wr(RegMask, 8'($urandom_range(0, 255)));
                rd(RegStatus);
            end
        endcase
    endtask

    task automatic test_random(int count);
        int stop;
        stop = requests_sent + count;
        while (requests_sent < stop) random_sequence();
        wait_drain();
    endtask

    // a full scanline of ticks with rendering on, back to back, with status reads mixed in
    task automatic test_render_lines();
        wr(RegCtrl, 8'h80);
        wr(RegMask, 8'h18);
        wr(RegScroll, 8'h5D);
        wr(RegScroll, 8'hEF);
        idle_on = 0;
        for (int i = 0; i < LineTicks; i++) begin
            if (i % 97 == 50) rd(RegStatus);
            else send_req(KIND_TICK, RegCtrl, 8'h00, 8'h00);
        end
        wait_drain();
        idle_on = 1;
    endtask

    task automatic test_stall();
        idle_on = 0;
        stall_left = 300;
        repeat (40) random_sequence();
        wait_drain();
        idle_on = 1;
        repeat (20) random_sequence();
        wait_drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.kind = KIND_TICK;
        req_bus.reg_select = RegCtrl;
        req_bus.data_in = 8'h00;
        req_bus.dma_index = 8'h00;
        res_bus.ready = 1'b0;
        mirror = 1'b0;
        ctrl_q = 0; mask_q = 0; oam_addr = 0; rd_buffer = 0;
        flags_q = 0; fine_x = 0; vaddr = 0; taddr = 0; toggle_q = 0;
        dot_q = 0; line_q = 0;
        foreach (palette_mem[i]) palette_mem[i] = 8'h00;
        foreach (oam_mem[i]) oam_mem[i] = 8'h00;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        set_mirror(1'b1);
        test_random(350);
        test_stall();
        set_mirror(1'b0);
        test_random(350);
        test_render_lines();
        set_mirror(1'b1);
        test_random(150);

        wait_drain();
        repeat (10) @(negedge i_clk);
        $display("covered %0d requests, %0d results, %0d nmi pulses, both mirror modes",
                 requests_sent, results_seen, nmi_seen);
        $display("including a scanline of render-time address updates and a long output stall");
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
